// ===== hw/rtl/sas_pkg.sv =====
// ----------------------------------------------------------------------------
// sas_pkg
// Shared codes, defaults and controller/datapath command types for the
// slot allocator with free-slot stack.
// ----------------------------------------------------------------------------
package sas_pkg;

  // Default sizing
  localparam int unsigned SLOT_COUNT_DEF = 1024;
  localparam int unsigned ID_WIDTH_DEF   = 16;

  // Operation codes carried on mode
  localparam logic [1:0] MODE_FILL   = 2'd0;
  localparam logic [1:0] MODE_REMOVE = 2'd1;
  localparam logic [1:0] MODE_READ   = 2'd2;
  localparam logic [1:0] MODE_WRITE  = 2'd3;

  // Result status codes
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;
  localparam logic [1:0] STAT_RANGE = 2'd3;

  // Controller to datapath commands
  typedef struct packed {
    logic clear;   // write one entry of the clearing pass
    logic launch;  // capture a word and issue the memory reads
    logic exec;    // decide, update memories and count, register the result
  } sas_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic clear_last;  // clearing pass is on its final entry
  } sas_stat_t;

endpackage

// ===== hw/rtl/slot_allocator_free_stack_core.sv =====
// ----------------------------------------------------------------------------
// slot_allocator_free_stack_core
// Slot allocator: free-slot stack plus a table of stored ids.
// ----------------------------------------------------------------------------
// Usage:
//   Raise start with mode, slot_index and dense_value while busy is low; the
//   word is taken at that clock edge. Modes: fill pops a free slot and stores
//   the id, remove pushes the slot back and returns its id, read and write
//   access one slot's id directly.
//   Each word has an accept cycle that issues registered reads of the
//   slot table and the stack top, then an execute cycle that decides and
//   writes both memories. Busy is high during execute, so no new word is
//   taken until execute is over. The result (slot_out, value_out, status,
//   occupied_count) is held with done for one cycle, the cycle after execute.
//   The receiver cannot stall; done is never held.
//   After reset a clearing pass writes every table entry invalid and every
//   stack entry k with k; busy stays high throughout. Writes to slot_limit
//   over the APB port are taken at any time.
// ----------------------------------------------------------------------------
module slot_allocator_free_stack_core #(
  parameter int unsigned SLOT_COUNT = sas_pkg::SLOT_COUNT_DEF,
  parameter int unsigned ID_WIDTH   = sas_pkg::ID_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // Command channel
  input  logic                            start,
  output logic                            busy,
  input  logic [1:0]                      mode,
  input  logic [$clog2(SLOT_COUNT)-1:0]   slot_index,
  input  logic [ID_WIDTH-1:0]             dense_value,
  // Result channel
  output logic                            done,
  output logic [$clog2(SLOT_COUNT)-1:0]   slot_out,
  output logic [ID_WIDTH-1:0]             value_out,
  output logic [1:0]                      status,
  output logic [$clog2(SLOT_COUNT+1)-1:0] occupied_count,
  // Configuration port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [2:0]                      paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);
  import sas_pkg::*;

  localparam int unsigned CNT_W = $clog2(SLOT_COUNT+1);

  sas_cmd_t         cmd;
  sas_stat_t        stat;
  logic             cfg_we;
  logic [CNT_W-1:0] limit;

  // Register 0 is slot_limit; address 4 lies beyond the list
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready && !paddr[2];
  assign prdata = paddr[2] ? 32'd0 : 32'(limit);

  sas_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  sas_datapath #(
    .SLOT_COUNT (SLOT_COUNT),
    .ID_WIDTH   (ID_WIDTH)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .mode           (mode),
    .slot_index     (slot_index),
    .dense_value    (dense_value),
    .cfg_we         (cfg_we),
    .cfg_wdata      (pwdata[CNT_W-1:0]),
    .limit          (limit),
    .done           (done),
    .slot_out       (slot_out),
    .value_out      (value_out),
    .status         (status),
    .occupied_count (occupied_count)
  );

  // A result only follows an execute cycle
  assert property (@(posedge clk) disable iff (rst) done |-> $past(cmd.exec))
    else $error("result strobe without an execute cycle");

  // An accepted word always moves into execute
  assert property (@(posedge clk) disable iff (rst) (start && !busy) |=> (busy && cmd.exec))
    else $error("accepted word not executed");

  // Occupancy never exceeds the table depth
  assert property (@(posedge clk) disable iff (rst)
    done |-> (occupied_count <= CNT_W'(SLOT_COUNT)))
    else $error("occupied count beyond table depth");

  // A full fill reports slot zero and the invalid id
  assert property (@(posedge clk) disable iff (rst)
    (done && (status == STAT_FULL)) |-> ((slot_out == '0) && (value_out == '1)))
    else $error("full status with a live slot or id");

endmodule

// ===== hw/rtl/sas_ctrl.sv =====
// ----------------------------------------------------------------------------
// sas_ctrl
// Sequencer: clearing pass after reset, then an accept step and an execute
// step for each word.
// ----------------------------------------------------------------------------
module sas_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  sas_pkg::sas_stat_t stat,
  output sas_pkg::sas_cmd_t  cmd,
  output logic             busy
);
  import sas_pkg::*;

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_EXEC  = 3'b100
  } sas_state_t;

  sas_state_t state;
  sas_state_t state_next;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (stat.clear_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Drive commands from the current state
  always_comb begin
    cmd.clear  = (state == ST_CLEAR);
    cmd.launch = (state == ST_IDLE) && start;
    cmd.exec   = (state == ST_EXEC);
  end

  assign busy = (state != ST_IDLE);

endmodule

// ===== hw/rtl/sas_datapath.sv =====
// ----------------------------------------------------------------------------
// sas_datapath
// Slot table and free-slot stack memories, occupancy count, limit register
// and the registered result word.
// ----------------------------------------------------------------------------
module sas_datapath #(
  parameter int unsigned SLOT_COUNT = sas_pkg::SLOT_COUNT_DEF,
  parameter int unsigned ID_WIDTH   = sas_pkg::ID_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  sas_pkg::sas_cmd_t                   cmd,
  output sas_pkg::sas_stat_t                  stat,
  input  logic [1:0]                          mode,
  input  logic [$clog2(SLOT_COUNT)-1:0]       slot_index,
  input  logic [ID_WIDTH-1:0]                 dense_value,
  input  logic                                cfg_we,
  input  logic [$clog2(SLOT_COUNT+1)-1:0]     cfg_wdata,
  output logic [$clog2(SLOT_COUNT+1)-1:0]     limit,
  output logic                                done,
  output logic [$clog2(SLOT_COUNT)-1:0]       slot_out,
  output logic [ID_WIDTH-1:0]                 value_out,
  output logic [1:0]                          status,
  output logic [$clog2(SLOT_COUNT+1)-1:0]     occupied_count
);
  import sas_pkg::*;

  localparam int unsigned IDX_W = $clog2(SLOT_COUNT);
  localparam int unsigned CNT_W = $clog2(SLOT_COUNT+1);
  localparam logic [ID_WIDTH-1:0] INVALID_ID = '1;
  localparam logic [CNT_W-1:0]    SLOT_MAX   = CNT_W'(SLOT_COUNT);
  localparam logic [IDX_W-1:0]    CLR_LAST   = IDX_W'(SLOT_COUNT - 1);

  // Memories
  logic [ID_WIDTH-1:0] tbl_mem [SLOT_COUNT];
  logic [IDX_W-1:0]    stk_mem [SLOT_COUNT];

  // Control registers
  logic [CNT_W-1:0]    used_count;
  logic [CNT_W-1:0]    used_count_next;
  logic [IDX_W-1:0]    clr_addr;

  // Captured word and read data
  logic [1:0]          mode_q;
  logic [IDX_W-1:0]    idx_q;
  logic [ID_WIDTH-1:0] val_q;
  logic [ID_WIDTH-1:0] tbl_rdata;
  logic [IDX_W-1:0]    stk_rdata;

  // Execute-cycle decisions
  logic                ex_tbl_we;
  logic [IDX_W-1:0]    ex_tbl_waddr;
  logic [ID_WIDTH-1:0] ex_tbl_wdata;
  logic                ex_stk_we;
  logic [IDX_W-1:0]    res_slot;
  logic [ID_WIDTH-1:0] res_val;
  logic [1:0]          res_stat;
  logic                is_full;
  logic                idx_beyond;
  logic [CNT_W-1:0]    used_dec;

  // Memory port muxes
  logic                tbl_we;
  logic [IDX_W-1:0]    tbl_waddr;
  logic [ID_WIDTH-1:0] tbl_wdata;
  logic                stk_we;
  logic [IDX_W-1:0]    stk_waddr;
  logic [IDX_W-1:0]    stk_wdata;
  logic [IDX_W-1:0]    stk_raddr;
  logic [CNT_W-1:0]    cfg_want;

  assign is_full    = (used_count >= limit);
  assign idx_beyond = (CNT_W'(idx_q) >= limit);
  assign used_dec   = used_count - CNT_W'(1);
  assign stk_raddr  = (used_count >= SLOT_MAX) ? '0 : used_count[IDX_W-1:0];

  assign stat.clear_last = (clr_addr == CLR_LAST);

  // Decide the operation on the registered read data
  always_comb begin
    used_count_next = used_count;
    ex_tbl_we       = 1'b0;
    ex_tbl_waddr    = idx_q;
    ex_tbl_wdata    = val_q;
    ex_stk_we       = 1'b0;
    res_slot        = idx_q;
    res_val         = INVALID_ID;
    res_stat        = STAT_OK;
    case (mode_q)
      MODE_FILL: begin
        if (is_full) begin
          res_stat = STAT_FULL;
          res_slot = '0;
        end else begin
          res_slot        = stk_rdata;
          ex_tbl_we       = 1'b1;
          ex_tbl_waddr    = stk_rdata;
          used_count_next = used_count + CNT_W'(1);
        end
      end
      MODE_REMOVE: begin
        if (idx_beyond) begin
          res_stat = STAT_RANGE;
        end else if ((used_count == '0) || (tbl_rdata == INVALID_ID)) begin
          res_stat = STAT_EMPTY;
        end else begin
          used_count_next = used_dec;
          ex_stk_we       = 1'b1;
          res_val         = tbl_rdata;
          ex_tbl_we       = 1'b1;
          ex_tbl_wdata    = INVALID_ID;
        end
      end
      MODE_READ: begin
        if (idx_beyond) begin
          res_stat = STAT_RANGE;
        end else begin
          res_val = tbl_rdata;
        end
      end
      MODE_WRITE: begin
        if (idx_beyond) begin
          res_stat = STAT_RANGE;
        end else begin
          ex_tbl_we = 1'b1;
        end
      end
      default: begin
        res_stat = STAT_OK;
      end
    endcase
  end

  // Share one write port per memory between the clearing pass and execute
  always_comb begin
    if (cmd.clear) begin
      tbl_we    = 1'b1;
      tbl_waddr = clr_addr;
      tbl_wdata = INVALID_ID;
      stk_we    = 1'b1;
      stk_waddr = clr_addr;
      stk_wdata = clr_addr;
    end else begin
      tbl_we    = cmd.exec && ex_tbl_we;
      tbl_waddr = ex_tbl_waddr;
      tbl_wdata = ex_tbl_wdata;
      stk_we    = cmd.exec && ex_stk_we;
      stk_waddr = used_dec[IDX_W-1:0];
      stk_wdata = idx_q;
    end
  end

  // Slot table: one write, one registered read
  always_ff @(posedge clk) begin
    if (tbl_we) tbl_mem[tbl_waddr] <= tbl_wdata;
    if (cmd.launch) tbl_rdata <= tbl_mem[slot_index];
  end

  // Free-slot stack: one write, one registered read at the top
  always_ff @(posedge clk) begin
    if (stk_we) stk_mem[stk_waddr] <= stk_wdata;
    if (cmd.launch) stk_rdata <= stk_mem[stk_raddr];
  end

  // Capture the word on accept
  always_ff @(posedge clk) begin
    if (cmd.launch) begin
      mode_q <= mode;
      idx_q  <= slot_index;
      val_q  <= dense_value;
    end
  end

  // Clamp the requested limit to the table depth
  assign cfg_want = (cfg_wdata > SLOT_MAX) ? SLOT_MAX : cfg_wdata;

  // Count, limit and clearing address
  always_ff @(posedge clk) begin
    if (rst) begin
      used_count <= '0;
      limit      <= SLOT_MAX;
      clr_addr   <= '0;
    end else begin
      if (cmd.exec) used_count <= used_count_next;
      // the limit only grows; new slots above it are already clean
      if (cfg_we && (cfg_want > limit)) limit <= cfg_want;
      if (cmd.clear) clr_addr <= clr_addr + IDX_W'(1);
    end
  end

  // Result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.exec;
    end
  end

  // Result word
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      slot_out       <= res_slot;
      value_out      <= res_val;
      status         <= res_stat;
      occupied_count <= used_count_next;
    end
  end

endmodule

// ===== bench/tb_slot_allocator_free_stack_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_slot_allocator_free_stack_core
// Self-checking bench for the slot allocator with its free-slot stack. A
// short scripted sequence covers the empty, invalid-id, LIFO reuse and direct
// write cases. Random stages then fill the table to full and drain much of it
// again. Every result word is compared with a behavioural model of the stack
// and id table, or with a script row's fixed result. slot_limit is written and
// read back between stages, with values below, at and above the table size.
// ----------------------------------------------------------------------------
module tb_slot_allocator_free_stack_core;
  import sas_pkg::*;

  localparam int SLOT_N = SLOT_COUNT_DEF;
  localparam int ID_W   = ID_WIDTH_DEF;
  localparam int SLOT_W = $clog2(SLOT_N);
  localparam int CNT_W  = $clog2(SLOT_N + 1);

  localparam logic [ID_W-1:0] ID_NONE         = '1;
  localparam logic [2:0]      ADDR_SLOT_LIMIT = 3'd0;

  typedef enum int {STAGE_MIX, STAGE_FILL, STAGE_DRAIN} stage_t;

  typedef struct packed {
    logic [1:0]        mode;
    logic [SLOT_W-1:0] slot_index;
    logic [ID_W-1:0]   dense_value;
  } alloc_word_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot_out;
    logic [ID_W-1:0]   value_out;
    logic [1:0]        status;
    logic [CNT_W-1:0]  occupied_count;
  } alloc_result_t;

  typedef struct packed {
    alloc_word_t   word;
    logic          typed;
    alloc_result_t result;
  } script_row_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic [1:0]        mode = MODE_READ;
  logic [SLOT_W-1:0] slot_index = '0;
  logic [ID_W-1:0]   dense_value = '0;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [2:0]        paddr = ADDR_SLOT_LIMIT;
  logic [31:0]       pwdata = '0;
  logic              busy;
  logic              done;
  logic [SLOT_W-1:0] slot_out;
  logic [ID_W-1:0]   value_out;
  logic [1:0]        status;
  logic [CNT_W-1:0]  occupied_count;
  logic [31:0]       prdata;
  logic              pready;

  // Shadow state of the allocator
  logic [ID_W-1:0]   slot_ids [SLOT_N];
  logic [SLOT_W-1:0] free_slots [SLOT_N];
  logic [CNT_W-1:0]  live_count;
  logic [CNT_W-1:0]  limit_shadow;

  alloc_result_t pending_results [$];
  script_row_t   script [$];
  int            fail_count = 0;
  int            words_sent = 0;
  int            words_checked = 0;
  int            full_seen = 0;
  int            empty_seen = 0;
  int            limit_writes = 0;

  slot_allocator_free_stack_core u_top (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .mode           (mode),
    .slot_index     (slot_index),
    .dense_value    (dense_value),
    .done           (done),
    .slot_out       (slot_out),
    .value_out      (value_out),
    .status         (status),
    .occupied_count (occupied_count),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Grow the limit: only upward, clamped to the table size, new slots free
  function automatic void grow_limit(input logic [31:0] data);
    logic [CNT_W-1:0] grow_to;
    grow_to = data[CNT_W-1:0];
    if (grow_to > SLOT_N) grow_to = CNT_W'(SLOT_N);
    if (grow_to > limit_shadow) begin
      for (int k = limit_shadow; k < grow_to; k++) begin
        slot_ids[k]   = ID_NONE;
        free_slots[k] = SLOT_W'(k);
      end
      limit_shadow = grow_to;
    end
  endfunction

  // Apply one command word to the shadow state and return its result word
  function automatic alloc_result_t allocate_or_access(input alloc_word_t w);
    alloc_result_t r;
    r.slot_out  = w.slot_index;
    r.value_out = ID_NONE;
    r.status    = STAT_OK;
    if (w.mode == MODE_FILL) begin
      if (live_count >= limit_shadow) begin
        r.status   = STAT_FULL;
        r.slot_out = '0;
      end else begin
        r.slot_out = free_slots[live_count[SLOT_W-1:0]];
        slot_ids[r.slot_out] = w.dense_value;
        live_count++;
      end
    end else if (w.slot_index >= limit_shadow) begin
      r.status = STAT_RANGE;
    end else if (w.mode == MODE_REMOVE) begin
      if (live_count == 0 || slot_ids[w.slot_index] == ID_NONE) begin
        r.status = STAT_EMPTY;
      end else begin
        live_count--;
        free_slots[live_count[SLOT_W-1:0]] = w.slot_index;
        r.value_out             = slot_ids[w.slot_index];
        slot_ids[w.slot_index]  = ID_NONE;
      end
    end else if (w.mode == MODE_READ) begin
      r.value_out = slot_ids[w.slot_index];
    end else begin
      slot_ids[w.slot_index] = w.dense_value;
    end
    r.occupied_count = live_count;
    return r;
  endfunction

  // First slot from a given point on that holds a valid id
  function automatic logic [SLOT_W-1:0] find_live(input int from);
    int k;
    for (int i = 0; i < SLOT_N; i++) begin
      k = (from + i) % SLOT_N;
      if (slot_ids[k] != ID_NONE) return SLOT_W'(k);
    end
    return SLOT_W'(from);
  endfunction

  function automatic script_row_t row_known(
    input logic [1:0] m, input int idx, input logic [ID_W-1:0] val,
    input int s, input logic [ID_W-1:0] v, input logic [1:0] st, input int c);
    script_row_t r;
    r.word   = '{m, SLOT_W'(idx), val};
    r.typed  = 1'b1;
    r.result = '{SLOT_W'(s), v, st, CNT_W'(c)};
    return r;
  endfunction

  function automatic script_row_t row_pred(
    input logic [1:0] m, input int idx, input logic [ID_W-1:0] val);
    script_row_t r;
    r.word   = '{m, SLOT_W'(idx), val};
    r.typed  = 1'b0;
    r.result = '0;
    return r;
  endfunction

  // Random word biased by stage; removes and reads mostly hit live slots
  function automatic alloc_word_t random_word(input stage_t stage);
    alloc_word_t w;
    int pick;
    int fill_pct;
    int remove_pct;
    pick       = $urandom_range(0, 99);
    fill_pct   = (stage == STAGE_FILL) ? 94 : (stage == STAGE_DRAIN) ? 2 : 40;
    remove_pct = (stage == STAGE_DRAIN) ? 94 : (stage == STAGE_FILL) ? 2 : 25;
    if (pick < fill_pct) w.mode = MODE_FILL;
    else if (pick < fill_pct + remove_pct) w.mode = MODE_REMOVE;
    else if (pick[0]) w.mode = MODE_READ;
    else w.mode = MODE_WRITE;
    w.slot_index = SLOT_W'($urandom);
    if (w.mode == MODE_WRITE) begin
      if ($urandom_range(0, 3) == 0) w.slot_index = find_live($urandom_range(0, SLOT_N - 1));
    end else if ($urandom_range(0, 3) != 0) begin
      w.slot_index = find_live($urandom_range(0, SLOT_N - 1));
    end
    case ($urandom_range(0, 31))
      0:       w.dense_value = '0;
      1:       w.dense_value = ID_NONE;
      default: w.dense_value = ID_W'($urandom);
    endcase
    return w;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] exp_v,
                                      input logic [31:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s mismatch: expected %0h, got %0h", name, exp_v, got_v);
      fail_count++;
    end
  endfunction

  // Hold a command word until the block takes it, then queue its result word
  task automatic send_word(input alloc_word_t w, input logic typed,
                           input alloc_result_t known);
    alloc_result_t want;
    int gap;
    start       <= 1'b1;
    mode        <= w.mode;
    slot_index  <= w.slot_index;
    dense_value <= w.dense_value;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    want = allocate_or_access(w);
    if (typed) want = known;
    pending_results.push_back(want);
    words_sent++;
    // random idle gap before the next word
    gap = $urandom_range(0, 3);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drop start and wait for every outstanding result word
  task automatic drain_results();
    int guard;
    guard = 0;
    start <= 1'b0;
    while (pending_results.size() > 0 && guard < 1000) begin
      @(posedge clk);
      guard++;
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic apb_xfer(input logic wr, input logic [31:0] data,
                          output logic [31:0] rd);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= ADDR_SLOT_LIMIT;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    rd = prdata;
    if (wr) grow_limit(data);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Write slot_limit, then read it back
  task automatic set_limit(input logic [31:0] data);
    logic [31:0] rd;
    apb_xfer(1'b1, data, rd);
    apb_xfer(1'b0, '0, rd);
    limit_writes++;
    if (rd[CNT_W-1:0] !== limit_shadow) begin
      $error("slot_limit readback mismatch: expected %0d, got %0d",
             limit_shadow, rd[CNT_W-1:0]);
      fail_count++;
    end
  endtask

  task automatic run_stage(input stage_t stage, input int cap);
    int extra;
    bit goal;
    extra = 0;
    for (int n = 0; n < cap && extra < 16; n++) begin
      send_word(random_word(stage), 1'b0, '0);
      goal = (stage == STAGE_FILL && live_count >= limit_shadow) ||
             (stage == STAGE_DRAIN && live_count == 0);
      if (goal) extra++;
    end
  endtask

  // Compare each result word with the oldest expectation
  always @(posedge clk) begin : check_results
    alloc_result_t want;
    if (!rst && done === 1'b1) begin
      if (pending_results.size() == 0) begin
        $error("result word with nothing expected: slot %0h value %0h status %0d",
               slot_out, value_out, status);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("slot_out", 32'(want.slot_out), 32'(slot_out));
        check_field("value_out", 32'(want.value_out), 32'(value_out));
        check_field("status", 32'(want.status), 32'(status));
        check_field("occupied_count", 32'(want.occupied_count), 32'(occupied_count));
        words_checked++;
        if (want.status == STAT_FULL) full_seen++;
        if (want.status == STAT_EMPTY) empty_seen++;
      end
    end
  end

  initial begin
    live_count   = '0;
    limit_shadow = '0;
    grow_limit(SLOT_N);

    // Empty table, invalid ids, LIFO reuse of removed slots, direct writes.
    // slot_limit can only grow from its reset of SLOT_N, so the index range
    // error never occurs with a 10-bit slot_index.
    script.push_back(row_known(MODE_READ,   0,      16'h0000, 0,    ID_NONE,  STAT_OK,    0));
    script.push_back(row_known(MODE_REMOVE, 0,      16'h0000, 0,    ID_NONE,  STAT_EMPTY, 0));
    script.push_back(row_known(MODE_READ,   1023,   16'hFFFF, 1023, ID_NONE,  STAT_OK,    0));
    script.push_back(row_known(MODE_FILL,   1023,   16'h0000, 0,    ID_NONE,  STAT_OK,    1));
    script.push_back(row_pred(MODE_FILL,    0,      ID_NONE));
    script.push_back(row_known(MODE_REMOVE, 1,      16'h0000, 1,    ID_NONE,  STAT_EMPTY, 2));
    script.push_back(row_pred(MODE_READ,    1,      16'h0000));
    script.push_back(row_pred(MODE_FILL,    0,      16'hA5A5));
    script.push_back(row_pred(MODE_READ,    2,      16'h0000));
    script.push_back(row_pred(MODE_REMOVE,  2,      16'h0000));
    script.push_back(row_pred(MODE_FILL,    0,      16'h5A5A));
    script.push_back(row_pred(MODE_REMOVE,  0,      16'h0000));
    script.push_back(row_pred(MODE_FILL,    0,      16'h1234));
    script.push_back(row_pred(MODE_WRITE,   1023,   16'hFFFE));
    script.push_back(row_pred(MODE_READ,    1023,   16'h0000));
    script.push_back(row_pred(MODE_REMOVE,  1023,   16'h0000));
    script.push_back(row_pred(MODE_FILL,    0,      16'h0001));
    script.push_back(row_pred(MODE_WRITE,   2,      ID_NONE));
    script.push_back(row_known(MODE_REMOVE, 2,      16'h0000, 2,    ID_NONE,  STAT_EMPTY, 3));
    script.push_back(row_pred(MODE_REMOVE,  10'h155, 16'h0000));
    script.push_back(row_pred(MODE_WRITE,   10'h2AA, 16'h8000));
    script.push_back(row_pred(MODE_READ,    10'h2AA, 16'h0000));
    script.push_back(row_pred(MODE_REMOVE,  10'h2AA, 16'h7FFF));
    script.push_back(row_pred(MODE_READ,    10'h155, 16'hFFFF));

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // A lower limit is ignored
    set_limit(32'd0);
    foreach (script[i]) send_word(script[i].word, script[i].typed, script[i].result);
    drain_results();

    // Above the table size: clamped
    set_limit(32'h0000_07FF);
    run_stage(STAGE_MIX, 100);
    drain_results();

    set_limit(32'd1);
    run_stage(STAGE_FILL, 1300);
    drain_results();

    // Only the low 11 bits count: this one reads as zero
    set_limit(32'hFFFF_F800);
    run_stage(STAGE_DRAIN, 720);
    drain_results();

    set_limit(SLOT_N);
    repeat (8) @(posedge clk);

    if (pending_results.size() > 0) begin
      $error("%0d result words never arrived", pending_results.size());
      fail_count++;
    end
    $display("Run covered %0d command words, %0d result words checked, %0d limit writes.",
             words_sent, words_checked, limit_writes);
    $display("Rejections seen: %0d fills on a full table, %0d removes of empty or free slots.",
             full_seen, empty_seen);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Hard stop well beyond the slowest correct run
  initial begin
    #3_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
